FILE: rtl/core/histogram_bin_counter_core_defines.svh
// Assertion helpers for the histogram bin counter.
`ifndef HISTOGRAM_BIN_COUNTER_CORE_DEFINES_SVH
`define HISTOGRAM_BIN_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/hbc_pkg.sv
`default_nettype none

package hbc_pkg;

	localparam int unsigned MAX_BINS_DEF    = 16;
	localparam int unsigned SAMPLE_BITS_DEF = 16;
	localparam int unsigned COUNT_BITS_DEF  = 32;

	// configuration port
	localparam int unsigned CFG_IDX_BITS  = 2;
	localparam int unsigned CFG_DATA_BITS = 16;
	localparam int unsigned LB_BITS       = 16;
	localparam int unsigned WIDTH_BITS    = 16;
	localparam int unsigned NBINS_BITS    = 5;

	localparam logic [CFG_IDX_BITS-1:0] REG_LOW_BOUND   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BIN_SPAN    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BINS_IN_USE = 2'd2;

	localparam logic [LB_BITS-1:0]    LOW_BOUND_RST   = 16'd0;
	localparam logic [WIDTH_BITS-1:0] BIN_SPAN_RST    = 16'd4096;
	localparam logic [NBINS_BITS-1:0] BINS_IN_USE_RST = 5'd16;

	// result field widths
	localparam int unsigned BIN_FIELD_BITS   = 4;
	localparam int unsigned COUNT_FIELD_BITS = 32;

	typedef logic [1:0] act_t;
	localparam act_t ACT_ADD   = 2'd0;
	localparam act_t ACT_READ  = 2'd1;
	localparam act_t ACT_CLEAR = 2'd2;

	// control part of the transaction moving down the cell row
	typedef struct packed {
		logic valid;
		act_t action;
		logic done;   // add already placed or rejected
		logic oor;
	} tok_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/hbc_cell.sv
`default_nettype none

module hbc_cell #(
	parameter int unsigned INDEX       = 0,
	parameter int unsigned MAX_BINS    = hbc_pkg::MAX_BINS_DEF,
	parameter int unsigned SAMPLE_BITS = hbc_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned COUNT_BITS  = hbc_pkg::COUNT_BITS_DEF
) (
	input  wire                                         clk,
	input  wire                                         arst_n,
	input  wire                                         advance,
	input  wire  [hbc_pkg::WIDTH_BITS-1:0]              w,
	input  wire  [((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1)-1:0] last_idx,
	input  wire  hbc_pkg::tok_ctl_t                     prev_ctl,
	input  wire  [SAMPLE_BITS-1:0]                      prev_d,
	input  wire  [((SAMPLE_BITS > hbc_pkg::WIDTH_BITS) ? SAMPLE_BITS : hbc_pkg::WIDTH_BITS)
		+ ((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1):0]   prev_edge,
	input  wire  [hbc_pkg::BIN_FIELD_BITS-1:0]          prev_rbin,
	input  wire  [hbc_pkg::BIN_FIELD_BITS-1:0]          prev_bin,
	input  wire  [COUNT_BITS-1:0]                       prev_count,
	output hbc_pkg::tok_ctl_t                           next_ctl,
	output logic [SAMPLE_BITS-1:0]                      next_d,
	output logic [((SAMPLE_BITS > hbc_pkg::WIDTH_BITS) ? SAMPLE_BITS : hbc_pkg::WIDTH_BITS)
		+ ((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1):0]   next_edge,
	output logic [hbc_pkg::BIN_FIELD_BITS-1:0]          next_rbin,
	output logic [hbc_pkg::BIN_FIELD_BITS-1:0]          next_bin,
	output logic [COUNT_BITS-1:0]                       next_count
);

	localparam int unsigned BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int unsigned BASE_W = (SAMPLE_BITS > hbc_pkg::WIDTH_BITS) ?
		SAMPLE_BITS : hbc_pkg::WIDTH_BITS;
	localparam int unsigned EDGE_W = BASE_W + BIN_W + 1;
	localparam int unsigned RBIN_RANGE = 1 << hbc_pkg::BIN_FIELD_BITS;
	localparam logic [BIN_W-1:0] MY_IDX = BIN_W'(INDEX);
	localparam logic READABLE = (INDEX < RBIN_RANGE);

	logic [COUNT_BITS-1:0] tally_q;
	logic [COUNT_BITS-1:0] tally_inc;
	logic [EDGE_W-1:0]     upper;
	logic [EDGE_W-1:0]     d_ext;
	logic                  active;
	logic                  is_last;
	logic                  is_add;
	logic                  hit_add;
	logic                  over;
	logic                  hit_read;
	logic                  do_clear;

	hbc_pkg::tok_ctl_t             ctl_q;
	hbc_pkg::tok_ctl_t             ctl_nxt;
	logic [SAMPLE_BITS-1:0]        d_q;
	logic [EDGE_W-1:0]             edge_q;
	logic [hbc_pkg::BIN_FIELD_BITS-1:0] rbin_q;
	logic [hbc_pkg::BIN_FIELD_BITS-1:0] bin_q;
	logic [hbc_pkg::BIN_FIELD_BITS-1:0] bin_nxt;
	logic [COUNT_BITS-1:0]         count_q;
	logic [COUNT_BITS-1:0]         count_nxt;

	// edge of this bin, relative to low_bound
	assign upper   = prev_edge + EDGE_W'(w);
	assign d_ext   = EDGE_W'(prev_d);
	assign active  = (MY_IDX <= last_idx);
	assign is_last = (MY_IDX == last_idx);
	assign is_add  = prev_ctl.valid && (prev_ctl.action == hbc_pkg::ACT_ADD) && !prev_ctl.done;

	// the last active bin also takes a sample sitting exactly on the top edge
	assign hit_add  = is_add && active && (is_last ? (d_ext <= upper) : (d_ext < upper));
	assign over     = is_add && is_last && (d_ext > upper);
	assign hit_read = prev_ctl.valid && (prev_ctl.action == hbc_pkg::ACT_READ) && READABLE
		&& (prev_rbin == hbc_pkg::BIN_FIELD_BITS'(INDEX));
	assign do_clear = prev_ctl.valid && (prev_ctl.action == hbc_pkg::ACT_CLEAR);

	assign tally_inc = (&tally_q) ? tally_q : tally_q + COUNT_BITS'(1);

	always_comb begin
		ctl_nxt   = prev_ctl;
		bin_nxt   = prev_bin;
		count_nxt = prev_count;
		if (hit_add) begin
			ctl_nxt.done = 1'b1;
			bin_nxt      = hbc_pkg::BIN_FIELD_BITS'(INDEX);
			count_nxt    = tally_inc;
		end else if (over) begin
			ctl_nxt.done = 1'b1;
			ctl_nxt.oor  = 1'b1;
		end else if (hit_read) begin
			count_nxt = tally_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= '0;
			tally_q <= '0;
		end else if (advance) begin
			ctl_q <= ctl_nxt;
			if (do_clear) begin
				tally_q <= '0;
			end else if (hit_add) begin
				tally_q <= tally_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			d_q     <= prev_d;
			edge_q  <= upper;
			rbin_q  <= prev_rbin;
			bin_q   <= bin_nxt;
			count_q <= count_nxt;
		end
	end

	assign next_ctl   = ctl_q;
	assign next_d     = d_q;
	assign next_edge  = edge_q;
	assign next_rbin  = rbin_q;
	assign next_bin   = bin_q;
	assign next_count = count_q;

endmodule

`default_nettype wire

FILE: rtl/core/histogram_bin_counter_core.sv
// Histogram bin counter. Each transaction (add a sample, read one bin, clear all bins) walks
// down a row of MAX_BINS cells, one cell per clock while the output is not stalled; every
// cell owns one saturating counter and the edge of its bin, which it forms from its neighbor's
// edge plus the bin span. The result passes each cell register, then the output register. The
// row carries a single transaction at a time, so the core takes no new one until the last has
// left the row; a finished result may sit in the output register while the next one runs.
// Out-of-range samples return bin 0, count 0 with out_of_range set. Counters reset to zero.
// The user must write configuration only when idle; the block itself does not enforce this.
`default_nettype none

module histogram_bin_counter_core #(
	parameter int unsigned MAX_BINS    = hbc_pkg::MAX_BINS_DEF,
	parameter int unsigned SAMPLE_BITS = hbc_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned COUNT_BITS  = hbc_pkg::COUNT_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire  [hbc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  wire  [hbc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  [1:0]                            action,
	input  wire  [SAMPLE_BITS-1:0]                sample,
	input  wire  [hbc_pkg::BIN_FIELD_BITS-1:0]    read_bin,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic [hbc_pkg::BIN_FIELD_BITS-1:0]    bin,
	output logic [hbc_pkg::COUNT_FIELD_BITS-1:0]  count,
	output logic                                  out_of_range
);

	localparam int unsigned BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int unsigned BASE_W = (SAMPLE_BITS > hbc_pkg::WIDTH_BITS) ?
		SAMPLE_BITS : hbc_pkg::WIDTH_BITS;
	localparam int unsigned EDGE_W = BASE_W + BIN_W + 1;
	localparam int unsigned N_W    = $clog2(MAX_BINS + 1);
	localparam int unsigned CMP_W  = (N_W > hbc_pkg::NBINS_BITS) ? N_W : hbc_pkg::NBINS_BITS;
	localparam int unsigned DIFF_W = BASE_W + 1;
	localparam int unsigned CW     = (COUNT_BITS > hbc_pkg::COUNT_FIELD_BITS) ?
		COUNT_BITS : hbc_pkg::COUNT_FIELD_BITS;

	logic [hbc_pkg::LB_BITS-1:0]    low_bound_q;
	logic [hbc_pkg::WIDTH_BITS-1:0] bin_span_q;
	logic [hbc_pkg::NBINS_BITS-1:0] bins_in_use_q;

	logic [hbc_pkg::WIDTH_BITS-1:0] w;
	logic [CMP_W-1:0]               n_raw;
	logic [BIN_W-1:0]               last_idx;
	logic [DIFF_W-1:0]              diff;
	logic                           below;
	logic                           accept;
	logic                           advance;
	logic                           out_free;
	logic                           busy_q;

	logic                           out_valid_q;
	logic [hbc_pkg::BIN_FIELD_BITS-1:0]   bin_q;
	logic [hbc_pkg::COUNT_FIELD_BITS-1:0] count_q;
	logic                           oor_q;
	logic [CW-1:0]                  count_wide;

	hbc_pkg::tok_ctl_t                  ctl_c   [MAX_BINS+1];
	logic [SAMPLE_BITS-1:0]             d_c     [MAX_BINS+1];
	logic [EDGE_W-1:0]                  edge_c  [MAX_BINS+1];
	logic [hbc_pkg::BIN_FIELD_BITS-1:0] rbin_c  [MAX_BINS+1];
	logic [hbc_pkg::BIN_FIELD_BITS-1:0] bin_c   [MAX_BINS+1];
	logic [COUNT_BITS-1:0]              count_c [MAX_BINS+1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bound_q   <= hbc_pkg::LOW_BOUND_RST;
			bin_span_q    <= hbc_pkg::BIN_SPAN_RST;
			bins_in_use_q <= hbc_pkg::BINS_IN_USE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hbc_pkg::REG_LOW_BOUND:   low_bound_q   <= cfg_data[hbc_pkg::LB_BITS-1:0];
				hbc_pkg::REG_BIN_SPAN:    bin_span_q    <= cfg_data[hbc_pkg::WIDTH_BITS-1:0];
				hbc_pkg::REG_BINS_IN_USE: bins_in_use_q <= cfg_data[hbc_pkg::NBINS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// zero width acts as one; bin count clamped to 1..MAX_BINS
	assign w     = (bin_span_q == '0) ? hbc_pkg::WIDTH_BITS'(1) : bin_span_q;
	assign n_raw = CMP_W'(bins_in_use_q);

	always_comb begin
		if (n_raw == '0) begin
			last_idx = '0;
		end else if (n_raw > CMP_W'(MAX_BINS)) begin
			last_idx = BIN_W'(MAX_BINS - 1);
		end else begin
			last_idx = BIN_W'(n_raw - CMP_W'(1));
		end
	end

	assign diff  = DIFF_W'(sample) - DIFF_W'(low_bound_q);
	assign below = diff[DIFF_W-1];

	assign accept   = in_valid && !busy_q;
	assign in_stall = busy_q;
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = !(ctl_c[MAX_BINS].valid && !out_free);

	// head of the row, fed straight from the input port
	always_comb begin
		ctl_c[0].valid  = accept;
		ctl_c[0].action = action;
		ctl_c[0].done   = (action == hbc_pkg::ACT_ADD) && below;
		ctl_c[0].oor    = (action == hbc_pkg::ACT_ADD) && below;
		d_c[0]          = diff[SAMPLE_BITS-1:0];
		edge_c[0]       = '0;
		rbin_c[0]       = read_bin;
		bin_c[0]        = (action == hbc_pkg::ACT_READ) ? read_bin : '0;
		count_c[0]      = '0;
	end

	for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
		hbc_cell #(
			.INDEX      (i),
			.MAX_BINS   (MAX_BINS),
			.SAMPLE_BITS(SAMPLE_BITS),
			.COUNT_BITS (COUNT_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.w         (w),
			.last_idx  (last_idx),
			.prev_ctl  (ctl_c[i]),
			.prev_d    (d_c[i]),
			.prev_edge (edge_c[i]),
			.prev_rbin (rbin_c[i]),
			.prev_bin  (bin_c[i]),
			.prev_count(count_c[i]),
			.next_ctl  (ctl_c[i+1]),
			.next_d    (d_c[i+1]),
			.next_edge (edge_c[i+1]),
			.next_rbin (rbin_c[i+1]),
			.next_bin  (bin_c[i+1]),
			.next_count(count_c[i+1])
		);
	end

	assign count_wide = CW'(count_c[MAX_BINS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (ctl_c[MAX_BINS].valid && out_free) begin
				busy_q <= 1'b0;
			end
			if (ctl_c[MAX_BINS].valid && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// rejected samples report bin 0, count 0
	always_ff @(posedge clk) begin
		if (ctl_c[MAX_BINS].valid && out_free) begin
			oor_q <= ctl_c[MAX_BINS].oor;
			if (ctl_c[MAX_BINS].oor) begin
				bin_q   <= '0;
				count_q <= '0;
			end else begin
				bin_q   <= bin_c[MAX_BINS];
				count_q <= count_wide[hbc_pkg::COUNT_FIELD_BITS-1:0];
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign bin          = bin_q;
	assign count        = count_q;
	assign out_of_range = oor_q;

endmodule

`default_nettype wire

FILE: rtl/core/hbc_checker.sv
`default_nettype none
`include "histogram_bin_counter_core_defines.svh"

module hbc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [3:0]  bin,
	input wire [31:0] count,
	input wire        out_of_range
);

	`HBC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
	`HBC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(count) && $stable(bin), "stalled result changed")
	`HBC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "second transaction taken while busy")
	`HBC_ASSERT_NOW(a_oor_zero, clk, arst_n, out_valid && out_of_range, (bin == 4'd0) && (count == 32'd0), "rejected sample reports nonzero bin or count")

endmodule

bind histogram_bin_counter_core hbc_checker u_hbc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.bin         (bin),
	.count       (count),
	.out_of_range(out_of_range)
);

`default_nettype wire
